/* src/bcd_digit_display_mux_core_defines.svh */
// Assertion macros shared by the RTL files of the display driver.
`ifndef BCD_DIGIT_DISPLAY_MUX_CORE_DEFINES_SVH
`define BCD_DIGIT_DISPLAY_MUX_CORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BCD_DD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the trigger holds, the check must hold at the next clock edge.
`define BCD_DD_ASSERT_NEXT(label, trig, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (chk)) \
      else $error(msg);

`endif

/* src/bcd_dd_pkg.sv */
package bcd_dd_pkg;

   localparam int VALUE_W    = 32;
   localparam int DCOUNT_W   = 2;
   localparam int SEL_W      = 2;
   localparam int BCD_W      = 4;
   localparam int HW_DIGITS  = 3;
   localparam int MAX_DIGITS = 3;

   localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 2'd3;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_TOO_LARGE = 1'b1;

   // One converted value as it leaves the conversion pipeline.
   typedef struct packed {
      logic                           too_large;
      logic [DCOUNT_W-1:0]            count;
      logic [HW_DIGITS-1:0][BCD_W-1:0] digs;
   } conv_item_type;

endpackage

/* src/bcd_dd_req_if.sv */
interface bcd_dd_req_if import bcd_dd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

/* src/bcd_dd_rsp_if.sv */
interface bcd_dd_rsp_if import bcd_dd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] digit_select;
   logic [BCD_W-1:0] bcd_value;
   logic             status;
   logic             last;

   modport source (output valid, output digit_select, output bcd_value,
                   output status, output last, input ready);
   modport sink   (input valid, input digit_select, input bcd_value,
                   input status, input last, output ready);
endinterface

/* src/bcd_dd_convert.sv */
module bcd_dd_convert import bcd_dd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [DCOUNT_W-1:0] digit_count,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [VALUE_W-1:0]  in_value,
   output logic                out_valid,
   input  logic                out_ready,
   output conv_item_type       out_item
);

   logic adv1, adv2, adv3;

   // Stage 1: range check against 10^count.
   logic                v1_ff, v1_in;
   logic [9:0]          val1_ff;
   logic [DCOUNT_W-1:0] cnt1_ff;
   logic                too1_ff;
   logic [9:0]          limit;
   logic                blank;

   // Stage 2: reciprocal quotients by 100 and by 10.
   logic                v2_ff;
   logic [9:0]          val2_ff;
   logic [DCOUNT_W-1:0] cnt2_ff;
   logic                too2_ff;
   logic [3:0]          hund2_ff;
   logic [6:0]          q10_2_ff;
   logic [15:0]         prod_h;
   logic [17:0]         prod_q;

   // Stage 3: remainders give the tens and ones digits.
   logic                v3_ff;
   conv_item_type       item3_ff;
   logic [9:0]          q_x10;
   logic [9:0]          ones_w;
   logic [6:0]          h_x10;
   logic [6:0]          tens_w;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      case (digit_count)
         2'd1:    limit = 10'd10;
         2'd2:    limit = 10'd100;
         default: limit = 10'd1000;
      endcase
   end

   assign blank = (digit_count == '0) ||
                  ({30'd0, digit_count} > 32'(MAX_DIGITS)) ||
                  ({30'd0, digit_count} > 32'(HW_DIGITS));
   assign v1_in = in_valid && !blank;

   assign prod_h = val1_ff * 6'd41;
   assign prod_q = val1_ff * 8'd205;

   assign q_x10  = {q10_2_ff, 3'b000} + {2'b00, q10_2_ff, 1'b0};
   assign ones_w = val2_ff - q_x10;
   assign h_x10  = {hund2_ff[3:0], 3'b000} + {2'b00, hund2_ff, 1'b0};
   assign tens_w = q10_2_ff - h_x10;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= v1_in;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         val1_ff <= in_value[9:0];
         cnt1_ff <= digit_count;
         too1_ff <= in_value >= {22'd0, limit};
      end
      if (adv2) begin
         val2_ff  <= val1_ff;
         cnt2_ff  <= cnt1_ff;
         too2_ff  <= too1_ff;
         hund2_ff <= prod_h[15:12];
         q10_2_ff <= prod_q[17:11];
      end
      if (adv3) begin
         item3_ff.too_large <= too2_ff;
         item3_ff.count     <= cnt2_ff;
         item3_ff.digs[0]   <= hund2_ff;
         item3_ff.digs[1]   <= tens_w[3:0];
         item3_ff.digs[2]   <= ones_w[3:0];
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;

endmodule

/* src/bcd_dd_serial.sv */
`include "bcd_digit_display_mux_core_defines.svh"

module bcd_dd_serial import bcd_dd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  conv_item_type in_item,
   bcd_dd_rsp_if.source  rsp_port
);

   logic             hold_v_ff;
   conv_item_type    item_ff;
   logic [SEL_W-1:0] idx_ff;

   logic             rsp_v_ff;
   logic [SEL_W-1:0] rsp_sel_ff;
   logic [BCD_W-1:0] rsp_bcd_ff;
   logic             rsp_status_ff;
   logic             rsp_last_ff;

   logic             emit_ok;
   logic             is_last;
   logic             emit;
   logic [SEL_W-1:0] pos;

   assign emit_ok  = !rsp_v_ff || rsp_port.ready;
   assign is_last  = item_ff.too_large || (idx_ff == item_ff.count - 2'd1);
   assign emit     = hold_v_ff && emit_ok;
   assign in_ready = !hold_v_ff || (emit_ok && is_last);
   // Right alignment: the first shown digit sits count places from the right.
   assign pos      = SEL_W'(HW_DIGITS) - item_ff.count + idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            hold_v_ff <= 1'b1;
         end else if (emit && is_last) begin
            hold_v_ff <= 1'b0;
         end
         if (emit_ok) begin
            rsp_v_ff <= hold_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
         idx_ff  <= '0;
      end else if (emit) begin
         idx_ff <= idx_ff + 2'd1;
      end
      if (emit) begin
         if (item_ff.too_large) begin
            rsp_sel_ff    <= '0;
            rsp_bcd_ff    <= '0;
            rsp_status_ff <= STATUS_TOO_LARGE;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_sel_ff    <= idx_ff;
            rsp_bcd_ff    <= item_ff.digs[pos];
            rsp_status_ff <= STATUS_OK;
            rsp_last_ff   <= is_last;
         end
      end
   end

   assign rsp_port.valid        = rsp_v_ff;
   assign rsp_port.digit_select = rsp_sel_ff;
   assign rsp_port.bcd_value    = rsp_bcd_ff;
   assign rsp_port.status       = rsp_status_ff;
   assign rsp_port.last         = rsp_last_ff;

   `BCD_DD_ASSERT_ALWAYS(a_too_large_single, !rsp_v_ff || rsp_status_ff == STATUS_OK || (rsp_last_ff && rsp_bcd_ff == '0 && rsp_sel_ff == '0), "too_large result must be a lone last result")
   `BCD_DD_ASSERT_ALWAYS(a_bcd_range, !rsp_v_ff || rsp_bcd_ff <= 4'd9, "bcd_value out of decimal range")
   `BCD_DD_ASSERT_ALWAYS(a_idx_in_count, !hold_v_ff || item_ff.too_large || idx_ff < item_ff.count, "digit index ran past digit count")
   `BCD_DD_ASSERT_NEXT(a_nonlast_continues, emit && !is_last, hold_v_ff, "item dropped before its last digit")

endmodule

/* src/bcd_digit_display_mux_core.sv */
// Channel   Direction  Payload                                     Handshake
// req_port  in         value[31:0]                                 valid/ready
// rsp_port  out        digit_select[1:0] bcd_value[3:0] status last valid/ready
// csr       in         csr_wdata[1:0] (digit_count)                csr_we strobe
//
// A value passes three register stages (range check, quotient multiply,
// remainder) and a serializer that sends one result per cycle while the
// result side is ready: digit_count results per item, or one when it is
// too large. Each result leaves through the serializer's output register.
// Reset is synchronous and active high; it empties the pipeline and sets
// digit_count to 3. A result stall backs up stage by stage with no loss.
`include "bcd_digit_display_mux_core_defines.svh"

module bcd_digit_display_mux_core import bcd_dd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [DCOUNT_W-1:0] csr_wdata,
   bcd_dd_req_if.sink          req_port,
   bcd_dd_rsp_if.source        rsp_port
);

   // Digit count register; the user must write it only while the block is
   // idle (the block does not enforce this), so the pipeline may sample it live.
   logic [DCOUNT_W-1:0] digit_count_ff;

   // Handoff between the conversion pipeline and the serializer.
   logic          conv_valid;
   logic          conv_ready;
   conv_item_type conv_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DCOUNT_RESET;
      end else if (csr_we) begin
         digit_count_ff <= csr_wdata;
      end
   end

   // Range check and binary to BCD conversion, three stages deep.
   bcd_dd_convert u_convert (
      .clock       (clock),
      .reset       (reset),
      .digit_count (digit_count_ff),
      .in_valid    (req_port.valid),
      .in_ready    (req_port.ready),
      .in_value    (req_port.value),
      .out_valid   (conv_valid),
      .out_ready   (conv_ready),
      .out_item    (conv_item)
   );

   // Splits one converted item into its digit results, most significant
   // first, or into one too-large result, through a registered output stage.
   bcd_dd_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (conv_valid),
      .in_ready (conv_ready),
      .in_item  (conv_item),
      .rsp_port (rsp_port)
   );

   // A converted item that is not too large always carries a usable count.
   `BCD_DD_ASSERT_ALWAYS(a_conv_count, !conv_valid || conv_item.too_large || conv_item.count != '0, "converted item with blank digit count")
   // A register write takes effect at the next clock edge.
   `BCD_DD_ASSERT_NEXT(a_csr_write, csr_we, digit_count_ff == $past(csr_wdata), "digit count write lost")
   // Digits of an item in range are decimal.
   `BCD_DD_ASSERT_ALWAYS(a_conv_digits, !conv_valid || conv_item.too_large || (conv_item.digs[0] <= 4'd9 && conv_item.digs[1] <= 4'd9 && conv_item.digs[2] <= 4'd9), "conversion produced a non-decimal digit")

endmodule

/* dv/bcd_dd_checker.sv */
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// digit count, predicts the digit results of every accepted value and
// compares them in order with what the block sends.
module bcd_dd_checker import bcd_dd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [DCOUNT_W-1:0] csr_wdata,
   bcd_dd_req_if               req_mon,
   bcd_dd_rsp_if               rsp_mon,
   output int unsigned         results_pending,
   output int unsigned         fail_count
);

   localparam int unsigned DECIMAL_BASE = 10;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SEL_W-1:0] digit_select;
      logic [BCD_W-1:0] bcd_value;
      logic             status;
      logic             last;
   } digit_result_type;

   digit_result_type    digits_due [$];
   logic [DCOUNT_W-1:0] digit_count;

   initial begin
      fail_count      = 0;
      results_pending = 0;
      digit_count     = DCOUNT_RESET;
   end

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Right-aligned decimal split of one value over the configured width.
   task automatic predict_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [BCD_W-1:0]   digs [HW_DIGITS];
      int                 width;
      digit_result_type   res;
      rest  = value;
      width = digit_count;
      if (width == 0 || width > MAX_DIGITS) begin
         return;
      end
      for (int i = width - 1; i >= 0; i--) begin
         digs[i] = BCD_W'(rest % DECIMAL_BASE);
         rest    = rest / DECIMAL_BASE;
      end
      if (rest != 0) begin
         res = '{digit_select: '0, bcd_value: '0, status: STATUS_TOO_LARGE, last: 1'b1};
         digits_due.push_back(res);
      end else begin
         for (int i = 0; i < width; i++) begin
            res = '{digit_select: SEL_W'(i), bcd_value: digs[i], status: STATUS_OK,
                    last: (i == width - 1)};
            digits_due.push_back(res);
         end
      end
   endtask

   task automatic check_digit();
      digit_result_type want;
      digit_result_type got;
      got = '{digit_select: rsp_mon.digit_select, bcd_value: rsp_mon.bcd_value,
              status: rsp_mon.status, last: rsp_mon.last};
      if (digits_due.size() == 0) begin
         report_failure($sformatf("unexpected result sel=%0d bcd=%0d status=%0d last=%0d",
                                  got.digit_select, got.bcd_value, got.status, got.last));
      end else begin
         want = digits_due.pop_front();
         if (want !== got) begin
            report_failure($sformatf(
               "result mismatch: expected sel=%0d bcd=%0d status=%0d last=%0d, got sel=%0d bcd=%0d status=%0d last=%0d",
               want.digit_select, want.bcd_value, want.status, want.last,
               got.digit_select, got.bcd_value, got.status, got.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         digit_count = DCOUNT_RESET;
         digits_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_digits(req_mon.value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_digit();
         end
         if (csr_we) begin
            digit_count = csr_wdata;
         end
      end
      results_pending <= digits_due.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the display driver. The checker beside the block
// does all prediction and comparison; this module only produces values,
// register writes and backpressure, and reports the outcome at the end.
module tb_top import bcd_dd_pkg::*; ;

   // Random values per phase with a nonzero digit count.
   localparam int unsigned ITEMS_PER_PHASE = 53;
   // Values sent while the display is blank; they leave no result.
   localparam int unsigned BLANK_ITEMS     = 20;
   // Cycles to wait past the last result: covers the pipeline stages and the
   // serializer, with margin for an item that leaves no result.
   localparam int unsigned DRAIN_SLACK     = 12;
   localparam int unsigned RUN_LIMIT_NS    = 4_000_000;
   localparam int unsigned PHASE_COUNT     = 8;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                csr_we    = 1'b0;
   logic [DCOUNT_W-1:0] csr_wdata = DCOUNT_RESET;

   bcd_dd_req_if req_chan ();
   bcd_dd_rsp_if rsp_chan ();

   int unsigned results_pending;
   int unsigned fail_count;

   // Idle level 0 means no gaps and no stalls; 1 to 3 make bursts more likely.
   int unsigned         idle_level = 1;
   int unsigned         stall_left = 0;
   logic [DCOUNT_W-1:0] display_width = DCOUNT_RESET;

   bcd_digit_display_mux_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_port  (req_chan),
      .rsp_port  (rsp_chan)
   );

   bcd_dd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .results_pending (results_pending),
      .fail_count      (fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
   end

   // The result side stalls in bursts whose length is drawn into stall_left. A burst
   // starts only when idling is enabled, so some stretches run with ready held high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b1;
         stall_left     <= 0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 4);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Offers one value and returns at the edge where it is accepted. Valid is
   // left high so that back-to-back values follow without a gap; a gap, when
   // one is drawn, lowers it first.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stops offering values and waits until every predicted result has come
   // back, then lets the pipeline settle so that a register write is safe.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Register writes happen only after a drain, with the block idle.
   task automatic write_digit_count(input logic [DCOUNT_W-1:0] count);
      csr_we        <= 1'b1;
      csr_wdata     <= count;
      display_width  = count;
      @(posedge clock);
      csr_we        <= 1'b0;
   endtask

   // Values are drawn relative to the current width: many fit, some sit right
   // at the overflow boundary, some just overflow, and the rest are full
   // 32-bit random values so that every input bit toggles.
   function automatic logic [VALUE_W-1:0] pick_value();
      longint unsigned limit;
      limit = 1;
      for (int i = 0; i < display_width; i++) begin
         limit = limit * 10;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return VALUE_W'($urandom_range(0, 32'(limit - 1)));
         4, 5:       return VALUE_W'(limit - 1 + $urandom_range(0, 2));
         6:          return VALUE_W'($urandom_range(32'(limit), 32'(limit * 10)));
         default:    return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      logic [VALUE_W-1:0]  wide_set    [9];
      logic [VALUE_W-1:0]  one_set     [4];
      logic [VALUE_W-1:0]  two_set     [4];
      logic [VALUE_W-1:0]  blank_set   [2];
      logic [DCOUNT_W-1:0] phase_width [PHASE_COUNT];
      int unsigned         phase_items;
      int unsigned         sent;

      wide_set    = '{32'd0, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                      32'd123, 32'hFFFF_FFFF};
      one_set     = '{32'd0, 32'd9, 32'd10, 32'hFFFF_FFFF};
      two_set     = '{32'd0, 32'd55, 32'd99, 32'd100};
      blank_set   = '{32'd5, 32'hFFFF_FFFF};
      phase_width = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The reset width of three digits is used first, with
      // both edges of each decade and the largest input value.
      idle_level = 1;
      foreach (wide_set[i]) send_value(wide_set[i]);
      drain_results();

      // The narrowest width, where ten already overflows.
      write_digit_count(2'd1);
      foreach (one_set[i]) send_value(one_set[i]);
      drain_results();

      write_digit_count(2'd2);
      foreach (two_set[i]) send_value(two_set[i]);
      drain_results();

      // A zero digit count blanks the display: values are taken but nothing
      // comes out.
      write_digit_count(2'd0);
      foreach (blank_set[i]) send_value(blank_set[i]);
      drain_results();

      // Random part. Each phase uses one width and ends with a full drain,
      // which also makes the sender wait for every outstanding result. The
      // idle level is redrawn every sixteen values; the final phase runs
      // with no gaps and no stalls at all.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_digit_count(phase_width[p]);
         phase_items = (phase_width[p] == 0) ? BLANK_ITEMS : ITEMS_PER_PHASE;
         sent = 0;
         while (sent < phase_items) begin
            if (sent % 16 == 0) begin
               idle_level = (p == PHASE_COUNT - 1) ? 0 : $urandom_range(0, 3);
            end
            send_value(pick_value());
            sent++;
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("bcd_digit_display_mux_core test passed");
      end else begin
         $display("bcd_digit_display_mux_core test failed");
      end
      $finish;
   end

   // A hung handshake or a missing result ends the run here.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("bcd_digit_display_mux_core test failed");
      $finish;
   end

endmodule
